>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication check failed");
`define ASSERT_NEVER(lbl, a) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMP(lbl, a, b)
`define ASSERT_NEVER(lbl, a)
`endif
`endif

>>> hw/rtl/spdp_pkg.sv
// Shared types, constants and helpers for the plane depth projection block.
// No dependencies.
package spdp_pkg;

  localparam int MAX_SEGMENTS_DEF = 1024;
  localparam int MAX_DIM_DEF      = 4096;
  localparam int FRAC_W           = 16;
  localparam int DVD_W            = 48;
  localparam int DVS_W            = 32;
  localparam int DIV_LAT          = DVD_W + 1;
  localparam int DR_W             = 30;

  typedef enum logic [1:0] {
    REG_FOCAL = 2'd0,
    REG_ZTHR  = 2'd1,
    REG_GRAD  = 2'd2,
    REG_TRAIN = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] depth;
    logic [27:0]        crow;
    logic [27:0]        ccol;
    logic signed [31:0] oa;
    logic signed [31:0] ob;
    logic signed [31:0] oc;
  } entry_t;

  typedef struct packed {
    logic                   vld;
    logic                   seg_bad;
    logic                   plain;
    logic                   grad;
    logic signed [31:0]     depth;
    logic signed [DR_W-1:0] dr;
    logic signed [DR_W-1:0] dc;
    logic signed [31:0]     ga;
    logic signed [31:0]     gb;
  } sb_t;

  // {clip, value}
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return {1'b1, 32'h7fff_ffff};
    else if (v < -64'sd2147483648) return {1'b1, 32'h8000_0000};
    else return {1'b0, v[31:0]};
  endfunction

  // divide by 2^16, truncating toward zero
  function automatic logic signed [63:0] trunc16(input logic signed [63:0] v);
    logic signed [63:0] b;
    b = v + (v[63] ? 64'sd65535 : 64'sd0);
    return b >>> FRAC_W;
  endfunction

endpackage

>>> hw/rtl/spdp_mem.sv
// Segment table: one entry per superpixel, one write and one registered read port.
// Depends on spdp_pkg.
module spdp_mem import spdp_pkg::*; #(
  parameter int DEPTH = MAX_SEGMENTS_DEF,
  parameter int AW    = $clog2(MAX_SEGMENTS_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem_q [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_r <= mem_q[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/spdp_div.sv
// Pipelined restoring divider, one quotient bit per stage, signed result saturated.
// Depends on spdp_pkg.
module spdp_div import spdp_pkg::*; (
  input  logic               clk,
  input  logic [DVD_W-1:0]   dvd_i,
  input  logic [DVS_W-1:0]   dvs_i,
  input  logic               neg_i,
  output logic signed [31:0] quo_o,
  output logic               clip_o
);

  logic [DVD_W-1:0] dvd_r [DVD_W];
  logic [DVS_W-1:0] rem_r [DVD_W];
  logic [DVS_W-1:0] dvs_r [DVD_W];
  logic             neg_r [DVD_W];
  logic [DVD_W-1:0] mag;
  logic signed [31:0] quo_r;
  logic             clip_r;

  for (genvar i = 0; i < DVD_W; i++) begin : g_stage
    logic [DVD_W-1:0] dvd_in;
    logic [DVS_W-1:0] rem_in;
    logic [DVS_W-1:0] dvs_in;
    logic             neg_in;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    if (i == 0) begin : g_first
      assign dvd_in = dvd_i;
      assign rem_in = '0;
      assign dvs_in = dvs_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign dvd_in = dvd_r[i-1];
      assign rem_in = rem_r[i-1];
      assign dvs_in = dvs_r[i-1];
      assign neg_in = neg_r[i-1];
    end
    assign trial = {rem_in, dvd_in[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_in};
    // shift quotient bits in as dividend bits move out
    always_ff @(posedge clk) begin
      dvs_r[i] <= dvs_in;
      neg_r[i] <= neg_in;
      if (!diff[DVS_W]) begin
        rem_r[i] <= diff[DVS_W-1:0];
        dvd_r[i] <= {dvd_in[DVD_W-2:0], 1'b1};
      end else begin
        rem_r[i] <= trial[DVS_W-1:0];
        dvd_r[i] <= {dvd_in[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign mag = dvd_r[DVD_W-1];

  always_ff @(posedge clk) begin
    if (neg_r[DVD_W-1]) begin
      if (mag > DVD_W'(48'h8000_0000)) begin
        quo_r  <= 32'sh8000_0000;
        clip_r <= 1'b1;
      end else begin
        quo_r  <= -$signed(mag[31:0]);
        clip_r <= 1'b0;
      end
    end else begin
      if (mag > DVD_W'(48'h7fff_ffff)) begin
        quo_r  <= 32'sh7fff_ffff;
        clip_r <= 1'b1;
      end else begin
        quo_r  <= $signed(mag[31:0]);
        clip_r <= 1'b0;
      end
    end
  end

  assign quo_o  = quo_r;
  assign clip_o = clip_r;

endmodule

>>> hw/rtl/superpixel_plane_depth_projection.sv
// Top level: config registers, segment table, three pipelined dividers and projection math.
// Depends on spdp_pkg, spdp_mem, spdp_div and assert_macros.svh.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+----------------------------------------------
//  input     | start / busy          | in_action, in_segment_id, load and pixel fields
//  result    | out_valid (strobe)    | out_projected_depth, out_plane_used, out_saturated
//  config    | psel/penable/pwrite   | paddr, pwdata, prdata
//
// One item is taken every cycle; busy stays low.
// Pixel results pass the table read, the 48-step divider pipe, then e1, e2, e3 and out.
// Loads write the table in the accept cycle and produce no result.
// rst_n (synchronous) clears config registers and pipeline valids; the table is not cleared.
// The receiver cannot stall: results flow out on out_valid.
module superpixel_plane_depth_projection import spdp_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int MAX_DIM      = MAX_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic [9:0]         in_segment_id,
  input  logic signed [31:0] in_seg_depth_in,
  input  logic [27:0]        in_center_row_in,
  input  logic [27:0]        in_center_col_in,
  input  logic signed [31:0] in_orient_a,
  input  logic signed [31:0] in_orient_b,
  input  logic signed [31:0] in_orient_c,
  input  logic [11:0]        in_pixel_row,
  input  logic [11:0]        in_pixel_col,
  output logic               out_valid,
  output logic signed [31:0] out_projected_depth,
  output logic               out_plane_used,
  output logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  `include "assert_macros.svh"

  localparam int AW       = $clog2(MAX_SEGMENTS);
  localparam int PIPE_LAT = DIV_LAT + 5;

  // ---------------- configuration ----------------
  logic [30:0] focal_r;
  logic [30:0] zthr_r;
  logic        grad_r;
  logic        train_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= 31'd65536;
      zthr_r  <= '0;
      grad_r  <= 1'b0;
      train_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_FOCAL: focal_r <= pwdata[30:0];
        REG_ZTHR:  zthr_r  <= pwdata[30:0];
        REG_GRAD:  grad_r  <= pwdata[0];
        REG_TRAIN: train_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_FOCAL: prdata = {1'b0, focal_r};
      REG_ZTHR:  prdata = {1'b0, zthr_r};
      REG_GRAD:  prdata = {31'd0, grad_r};
      REG_TRAIN: prdata = {31'd0, train_r};
      default:   prdata = '0;
    endcase
  end

  // ---------------- accept and table access ----------------
  logic          accept;
  logic [31:0]   seg_ext;
  logic          seg_ok;
  logic [AW-1:0] seg_addr;
  logic [16:0]   row_ext;
  logic [16:0]   col_ext;
  logic [11:0]   row_c;
  logic [11:0]   col_c;
  entry_t        wentry;
  entry_t        rentry;

  assign busy     = 1'b0;
  assign accept   = start & ~busy;
  assign seg_ext  = 32'(in_segment_id);
  assign seg_ok   = seg_ext < 32'(MAX_SEGMENTS);
  assign seg_addr = seg_ext[AW-1:0];
  assign row_ext  = 17'(in_pixel_row);
  assign col_ext  = 17'(in_pixel_col);
  assign row_c    = (row_ext >= 17'(MAX_DIM)) ? 12'(MAX_DIM - 1) : in_pixel_row;
  assign col_c    = (col_ext >= 17'(MAX_DIM)) ? 12'(MAX_DIM - 1) : in_pixel_col;

  assign wentry.depth = in_seg_depth_in;
  assign wentry.crow  = in_center_row_in;
  assign wentry.ccol  = in_center_col_in;
  assign wentry.oa    = in_orient_a;
  assign wentry.ob    = in_orient_b;
  assign wentry.oc    = in_orient_c;

  spdp_mem #(.DEPTH(MAX_SEGMENTS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (accept & ~in_action & seg_ok),
    .waddr (seg_addr),
    .wdata (wentry),
    .raddr (seg_addr),
    .rdata (rentry)
  );

  logic        s0_vld_r;
  logic        s0_bad_r;
  logic [11:0] s0_row_r;
  logic [11:0] s0_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept & in_action;
    end
    s0_bad_r <= ~seg_ok;
    s0_row_r <= row_c;
    s0_col_r <= col_c;
  end

  // ---------------- plane setup ----------------
  logic [32:0]            az;
  logic [32:0]            ax;
  logic [32:0]            ay;
  logic [32:0]            ad;
  logic                   z_small;
  logic                   clamp;
  logic [31:0]            zc_mag;
  logic                   zc_neg;
  logic [31:0]            focal_dvs;
  sb_t                    sb_in;

  assign az = rentry.oc[31]    ? (33'd0 - {1'b1, rentry.oc})    : {1'b0, rentry.oc};
  assign ax = rentry.oa[31]    ? (33'd0 - {1'b1, rentry.oa})    : {1'b0, rentry.oa};
  assign ay = rentry.ob[31]    ? (33'd0 - {1'b1, rentry.ob})    : {1'b0, rentry.ob};
  assign ad = rentry.depth[31] ? (33'd0 - {1'b1, rentry.depth}) : {1'b0, rentry.depth};

  assign z_small   = az < {2'b00, zthr_r};
  assign clamp     = z_small & train_r;
  assign zc_mag    = clamp ? {1'b0, zthr_r} : az[31:0];
  // clamp sign: positive only when z was strictly positive
  assign zc_neg    = clamp ? ~(~rentry.oc[31] & (rentry.oc != 32'sd0)) : rentry.oc[31];
  assign focal_dvs = (focal_r == 31'd0) ? 32'd1 : {1'b0, focal_r};

  assign sb_in.vld     = s0_vld_r;
  assign sb_in.seg_bad = s0_bad_r;
  assign sb_in.plain   = ~grad_r & ((z_small & ~train_r) | (zc_mag == 32'd0));
  assign sb_in.grad    = grad_r;
  assign sb_in.depth   = rentry.depth;
  assign sb_in.dr      = $signed({2'b00, s0_row_r, 16'h0}) - $signed({2'b00, rentry.crow});
  assign sb_in.dc      = $signed({2'b00, s0_col_r, 16'h0}) - $signed({2'b00, rentry.ccol});
  assign sb_in.ga      = rentry.oa;
  assign sb_in.gb      = rentry.ob;

  logic signed [31:0] dxq, dyq, qq;
  logic               clip_x, clip_y, clip_q;

  spdp_div u_div_x (
    .clk    (clk),
    .dvd_i  ({ax[31:0], 16'h0}),
    .dvs_i  (zc_mag),
    .neg_i  (~rentry.oa[31] ^ zc_neg),
    .quo_o  (dxq),
    .clip_o (clip_x)
  );

  spdp_div u_div_y (
    .clk    (clk),
    .dvd_i  ({ay[31:0], 16'h0}),
    .dvs_i  (zc_mag),
    .neg_i  (~rentry.ob[31] ^ zc_neg),
    .quo_o  (dyq),
    .clip_o (clip_y)
  );

  spdp_div u_div_q (
    .clk    (clk),
    .dvd_i  ({ad[31:0], 16'h0}),
    .dvs_i  (focal_dvs),
    .neg_i  (rentry.depth[31]),
    .quo_o  (qq),
    .clip_o (clip_q)
  );

  // hold side data alongside the divider pipe
  sb_t sb_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        sb_r[i] <= '0;
      end
    end else begin
      sb_r[0] <= sb_in;
      for (int i = 1; i < DIV_LAT; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  // ---------------- projection ----------------
  sb_t                t0;
  logic signed [31:0] dx_s, dy_s;
  logic               clip0;
  logic signed [61:0] pa_c, pb_c;

  assign t0    = sb_r[DIV_LAT-1];
  assign dx_s  = t0.grad ? t0.ga : dxq;
  assign dy_s  = t0.grad ? t0.gb : dyq;
  assign clip0 = (~t0.grad & (clip_x | clip_y)) | clip_q;
  assign pa_c  = t0.dr * dy_s;
  assign pb_c  = t0.dc * dx_s;

  logic               e1_vld_r, e1_bad_r, e1_plain_r, e1_clip_r;
  logic signed [31:0] e1_depth_r, e1_q_r;
  logic signed [61:0] e1_pa_r, e1_pb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
    end else begin
      e1_vld_r <= t0.vld;
    end
    e1_bad_r   <= t0.seg_bad;
    e1_plain_r <= t0.plain;
    e1_clip_r  <= clip0;
    e1_depth_r <= t0.depth;
    e1_q_r     <= qq;
    e1_pa_r    <= pa_c;
    e1_pb_r    <= pb_c;
  end

  logic signed [63:0] sum_c;
  logic [32:0]        s_sat;

  assign sum_c = 64'(e1_pa_r) + 64'(e1_pb_r);
  assign s_sat = sat32(trunc16(sum_c));

  logic               e2_vld_r, e2_bad_r, e2_plain_r, e2_clip_r;
  logic signed [31:0] e2_depth_r, e2_q_r, e2_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_vld_r <= 1'b0;
    end else begin
      e2_vld_r <= e1_vld_r;
    end
    e2_bad_r   <= e1_bad_r;
    e2_plain_r <= e1_plain_r;
    e2_clip_r  <= e1_clip_r | s_sat[32];
    e2_depth_r <= e1_depth_r;
    e2_q_r     <= e1_q_r;
    e2_s_r     <= $signed(s_sat[31:0]);
  end

  logic               e3_vld_r, e3_bad_r, e3_plain_r, e3_clip_r;
  logic signed [31:0] e3_depth_r;
  logic signed [63:0] e3_qs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e3_vld_r <= 1'b0;
    end else begin
      e3_vld_r <= e2_vld_r;
    end
    e3_bad_r   <= e2_bad_r;
    e3_plain_r <= e2_plain_r;
    e3_clip_r  <= e2_clip_r;
    e3_depth_r <= e2_depth_r;
    e3_qs_r    <= e2_q_r * e2_s_r;
  end

  logic [32:0] r_sat;
  assign r_sat = sat32(64'(e3_depth_r) + trunc16(e3_qs_r));

  logic               out_valid_r;
  logic signed [31:0] out_depth_r;
  logic               out_plane_r;
  logic               out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= e3_vld_r;
    end
    if (e3_bad_r) begin
      out_depth_r <= '0;
    end else if (e3_plain_r) begin
      out_depth_r <= e3_depth_r;
    end else begin
      out_depth_r <= $signed(r_sat[31:0]);
    end
    out_plane_r <= ~e3_bad_r & ~e3_plain_r;
    out_sat_r   <= ~e3_bad_r & ~e3_plain_r & (e3_clip_r | r_sat[32]);
  end

  assign out_valid           = out_valid_r;
  assign out_projected_depth = out_depth_r;
  assign out_plane_used      = out_plane_r;
  assign out_saturated       = out_sat_r;

  // ---------------- checks ----------------
  `ASSERT_NEVER(a_sat_needs_plane, out_valid && out_saturated && !out_plane_used)
  `ASSERT_IMP(a_result_from_pixel, out_valid, $past(start && !busy && in_action, PIPE_LAT))
  `ASSERT_IMP(a_plain_keeps_depth, e3_vld_r && e3_plain_r && !e3_bad_r, ##1 out_projected_depth == $past(e3_depth_r))

endmodule

>>> bench/superpixel_plane_depth_projection_tb.sv
// Self-checking bench for superpixel_plane_depth_projection: loads segment entries, projects pixels,
// predicts each result in-bench and checks it. Depends on spdp_pkg and the RTL top level.
`timescale 1ns / 100ps

module superpixel_plane_depth_projection_tb import spdp_pkg::*;;

  localparam int NSEG = 1024;
  localparam int PIPE_WAIT = 60;

  typedef struct {
    bit          action;
    logic [9:0]  seg;
    logic [31:0] depth;
    logic [27:0] crow;
    logic [27:0] ccol;
    logic [31:0] oa;
    logic [31:0] ob;
    logic [31:0] oc;
    logic [11:0] prow;
    logic [11:0] pcol;
  } beat_t;

  typedef struct {
    logic [31:0] pd;
    bit          pu;
    bit          sat;
  } proj_t;

  logic clk = 0, rst_n = 0, start = 0;
  logic busy;
  logic in_action = 0;
  logic [9:0] in_segment_id = 0;
  logic signed [31:0] in_seg_depth_in = 0, in_orient_a = 0, in_orient_b = 0, in_orient_c = 0;
  logic [27:0] in_center_row_in = 0, in_center_col_in = 0;
  logic [11:0] in_pixel_row = 0, in_pixel_col = 0;
  logic out_valid, out_plane_used, out_saturated;
  logic signed [31:0] out_projected_depth;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  superpixel_plane_depth_projection i_dut (.*);

  // predictor state
  int          tb_depth[NSEG], tb_oa[NSEG], tb_ob[NSEG], tb_oc[NSEG];
  longint      tb_crow[NSEG], tb_ccol[NSEG];
  bit          loaded[NSEG];
  int          loaded_ids[$];
  longint      focal_q = 65536, zthr_q = 0;
  bit          grad_q = 0, train_q = 1;

  beat_t pending[$];
  proj_t depth_expected[$];
  beat_t cur;
  int    idle_pct = 0;
  int    errors = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #(5ms);
    $display("superpixel_plane_depth_projection_tb NOT OK");
    $finish;
  end

  function automatic longint clamp32(input longint v, inout bit c);
    if (v > 64'sd2147483647) begin c = 1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin c = 1; return -64'sd2147483648; end
    return v;
  endfunction

  task automatic store_or_project(input beat_t b);
    int k;
    bit c;
    longint d, x, y, z, az, dx, dy, q, dr, dc, s, res;
    proj_t p;
    k = int'(b.seg);
    c = 0;
    if (!b.action) begin
      tb_depth[k] = b.depth; tb_crow[k] = b.crow; tb_ccol[k] = b.ccol;
      tb_oa[k] = b.oa; tb_ob[k] = b.ob; tb_oc[k] = b.oc;
      return;
    end
    d = tb_depth[k];
    if (grad_q) begin
      dx = tb_oa[k]; dy = tb_ob[k];
    end else begin
      x = tb_oa[k]; y = tb_ob[k]; z = tb_oc[k];
      az = z < 0 ? -z : z;
      if (az < zthr_q) z = train_q ? (z > 0 ? zthr_q : -zthr_q) : 0;
      if (z == 0) begin
        p.pd = d[31:0]; p.pu = 0; p.sat = 0;
        depth_expected.push_back(p);
        return;
      end
      dx = clamp32((-x * 65536) / z, c);
      dy = clamp32((-y * 65536) / z, c);
    end
    q = clamp32((d * 65536) / (focal_q != 0 ? focal_q : 64'sd1), c);
    dr = longint'(b.prow) * 65536 - tb_crow[k];
    dc = longint'(b.pcol) * 65536 - tb_ccol[k];
    s = clamp32((dr * dy + dc * dx) / 65536, c);
    res = clamp32(d + (q * s) / 65536, c);
    p.pd = res[31:0]; p.pu = 1; p.sat = c;
    depth_expected.push_back(p);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
    end else begin
      if (start && !busy) store_or_project(cur);
      if (pending.size() > 0 && !(start && busy) && $urandom_range(99) >= idle_pct) begin
        cur = pending.pop_front();
        in_action <= cur.action; in_segment_id <= cur.seg;
        in_seg_depth_in <= cur.depth; in_center_row_in <= cur.crow;
        in_center_col_in <= cur.ccol; in_orient_a <= cur.oa; in_orient_b <= cur.ob;
        in_orient_c <= cur.oc; in_pixel_row <= cur.prow; in_pixel_col <= cur.pcol;
        start <= 1;
      end else if (!(start && busy)) begin
        start <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    proj_t p;
    if (rst_n && out_valid) begin
      if (depth_expected.size() == 0) begin
        $error("unexpected result beat: projected_depth %h", out_projected_depth);
        errors++;
      end else begin
        p = depth_expected.pop_front();
        if (out_projected_depth !== p.pd) begin
          $error("projected_depth: expected %h actual %h", p.pd, out_projected_depth);
          errors++;
        end
        if (out_plane_used !== p.pu) begin
          $error("plane_used: expected %0d actual %0d", p.pu, out_plane_used);
          errors++;
        end
        if (out_saturated !== p.sat) begin
          $error("saturated: expected %0d actual %0d", p.sat, out_saturated);
          errors++;
        end
      end
    end
  end

  function automatic beat_t load_beat(input int seg);
    beat_t b;
    b.action = 0; b.seg = 10'(seg);
    b.depth = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h00ff_ffff);
    if ($urandom_range(3) == 0) b.depth = -b.depth;
    b.crow = 28'($urandom); b.ccol = 28'($urandom);
    b.oa = $urandom; b.ob = $urandom;
    if ($urandom_range(1)) begin
      b.oa = $signed(b.oa) >>> $urandom_range(16);
      b.ob = $signed(b.ob) >>> $urandom_range(16);
    end
    case ($urandom_range(4))
      0: b.oc = 0;
      1: b.oc = $urandom_range(zthr_q > 0 ? 32'(2 * zthr_q) : 32'd8);
      2: b.oc = -$urandom_range(zthr_q > 0 ? 32'(2 * zthr_q) : 32'd8);
      default: b.oc = $urandom;
    endcase
    b.prow = 12'($urandom); b.pcol = 12'($urandom);
    return b;
  endfunction

  function automatic beat_t pixel_beat(input int seg);
    beat_t b;
    b = load_beat(seg);
    b.action = 1;
    return b;
  endfunction

  task automatic push_load(input beat_t b);
    if (!loaded[b.seg]) begin loaded[b.seg] = 1; loaded_ids.push_back(int'(b.seg)); end
    pending.push_back(b);
  endtask

  task automatic drain();
    while (pending.size() > 0 || start || depth_expected.size() > 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_FOCAL: focal_q = v[30:0];
      REG_ZTHR:  zthr_q = v[30:0];
      REG_GRAD:  grad_q = v[0];
      REG_TRAIN: train_q = v[0];
    endcase
  endtask

  initial begin
    beat_t b;
    int n;
    logic [31:0] fv[6] = '{32'h0001_0000, 32'h0, 32'h7fff_ffff, 32'hffff_ffff,
                           32'h0000_0100, 32'h0200_0000};
    logic [31:0] zv[6] = '{32'h0, 32'h7fff_ffff, 32'h0001_0000, 32'h0000_4000,
                           32'hffff_ffff, 32'h0000_0001};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, zero and small z, both table ends
    b = load_beat(0); b.depth = 32'h7fff_ffff; b.crow = 0; b.ccol = 0;
    b.oa = 32'h8000_0000; b.ob = 32'h7fff_ffff; b.oc = 1; push_load(b);
    b = load_beat(1023); b.depth = 32'h8000_0000; b.crow = 28'hfff_ffff;
    b.ccol = 28'hfff_ffff; b.oa = 32'h7fff_ffff; b.ob = 32'h8000_0000;
    b.oc = 32'h8000_0000; push_load(b);
    b = load_beat(5); b.oc = 0; push_load(b);
    b = load_beat(6); b.depth = 32'h0002_0000; b.oa = 32'h0000_8000; b.ob = -32'sh8000;
    b.oc = 32'h0001_0000; b.crow = 28'h00a_0000; b.ccol = 28'h014_0000; push_load(b);
    b = load_beat(7); b.oc = 32'h0000_0010; push_load(b);
    b = load_beat(8); b.oc = -32'sh10; push_load(b);
    foreach (loaded_ids[i]) begin
      b = pixel_beat(loaded_ids[i]); b.prow = 0; b.pcol = 12'hfff; pending.push_back(b);
      b = pixel_beat(loaded_ids[i]); b.prow = 12'hfff; b.pcol = 0; pending.push_back(b);
    end
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        reg_write(REG_FOCAL, ph < 6 ? fv[ph] : $urandom);
        reg_write(REG_ZTHR, ph < 6 ? zv[ph] : (32'h1 << $urandom_range(20)));
        reg_write(REG_GRAD, 32'(ph % 3 == 2));
        reg_write(REG_TRAIN, 32'(ph % 2));
      end
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 75;
        default: idle_pct = 17;
      endcase
      n = 0;
      while (n < 50) begin
        if (loaded_ids.size() == 0 || $urandom_range(99) < 30) begin
          push_load(load_beat($urandom_range(NSEG - 1)));
        end else begin
          pending.push_back(pixel_beat(loaded_ids[$urandom_range(loaded_ids.size() - 1)]));
        end
        n++;
      end
      drain();
    end

    if (errors == 0)
      $display("superpixel_plane_depth_projection_tb OK");
    else
      $display("superpixel_plane_depth_projection_tb NOT OK");
    $finish;
  end
endmodule
